FILE: rtl/core/fra_pkg.sv
package fra_pkg;

  // operand width default and fixed field widths
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int IN_FIELD_W        = 16;
  localparam int CMD_W             = 2;
  localparam int RES_NUM_W         = 33;
  localparam int RES_DEN_W         = 32;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_SUB = 2'd1;
  localparam cmd_t CMD_MUL = 2'd2;
  localparam cmd_t CMD_DIV = 2'd3;

endpackage

FILE: rtl/core/fraction_arith_reduce.sv
// Fraction arithmetic with reduction: one transaction carries an operation (add, subtract,
// multiply, divide) and two signed fractions; the result is the cross-multiplied fraction
// divided by the greatest common divisor of its magnitudes, signs of numerator and
// denominator kept apart and not normalized. A zero denominator, or a divide by a zero
// numerator, returns 0/0 with status 1. Items are processed one at a time and in_stall
// stays high until the result is handed to the output register. With W = OPERAND_WIDTH
// and N = 2W+1, an item passes through the shared multiplier and the N-bit sum, then,
// when both magnitudes are at least 2, through a binary GCD on one shared subtractor
// (with the common-power-of-two strip and restore) and two bit-serial N-bit divisions
// on that same subtractor; an error item goes straight to the output register.
module fraction_arith_reduce
  import fra_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [CMD_W-1:0]            in_cmd,
  input  logic signed [IN_FIELD_W-1:0] in_a_num,
  input  logic signed [IN_FIELD_W-1:0] in_a_den,
  input  logic signed [IN_FIELD_W-1:0] in_b_num,
  input  logic signed [IN_FIELD_W-1:0] in_b_den,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [RES_NUM_W-1:0] out_res_num,
  output logic signed [RES_DEN_W-1:0] out_res_den,
  output logic                        out_status
);

  localparam int W   = OPERAND_WIDTH;
  localparam int PW  = 2 * W;
  localparam int NW  = PW + 1;
  localparam int XW  = (W > IN_FIELD_W) ? W : IN_FIELD_W;
  localparam int ENW = (NW > RES_NUM_W) ? NW : RES_NUM_W;
  localparam int EDW = (PW > RES_DEN_W) ? PW : RES_DEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_RED  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  function automatic logic [W-1:0] take_mag(input logic [W-1:0] raw);
    logic [W-1:0] m;
    m = raw[W-1] ? ((~raw) + 1'b1) : raw;
    return m;
  endfunction

  logic [2:0]    state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic          err_r, err_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [W-1:0]  am_r, adm_r, bm_r, bdm_r;
  logic [W-1:0]  am_nxt, adm_nxt, bm_nxt, bdm_nxt;
  logic          as_r, ads_r, bs_r, bds_r;
  logic          as_nxt, ads_nxt, bs_nxt, bds_nxt;
  logic [PW-1:0] pa_r, pa_nxt, pb_r, pb_nxt, dn_r, dn_nxt;
  logic          pas_r, pas_nxt, pbs_r, pbs_nxt;
  logic [NW-1:0] nm_r, nm_nxt;
  logic          nms_r, nms_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [RES_NUM_W-1:0] out_res_num_r, out_res_num_nxt;
  logic [RES_DEN_W-1:0] out_res_den_r, out_res_den_nxt;
  logic                 out_status_r, out_status_nxt;

  // operand capture
  logic [XW-1:0] a_num_x, a_den_x, b_num_x, b_den_x;
  logic [W-1:0]  a_num_m, a_den_m, b_num_m, b_den_m;
  logic          in_err;

  assign a_num_x = XW'($unsigned(in_a_num));
  assign a_den_x = XW'($unsigned(in_a_den));
  assign b_num_x = XW'($unsigned(in_b_num));
  assign b_den_x = XW'($unsigned(in_b_den));
  assign a_num_m = take_mag(a_num_x[W-1:0]);
  assign a_den_m = take_mag(a_den_x[W-1:0]);
  assign b_num_m = take_mag(b_num_x[W-1:0]);
  assign b_den_m = take_mag(b_den_x[W-1:0]);
  assign in_err  = (a_den_m == '0) || (b_den_m == '0) ||
                   ((in_cmd == CMD_DIV) && (b_num_m == '0));

  // shared multiplier
  logic [W-1:0]  mx, my;
  logic [PW-1:0] prod;
  logic          addsub;
  logic          last_step;

  assign addsub    = (cmd_r == CMD_ADD) || (cmd_r == CMD_SUB);
  assign last_step = addsub ? (step_r == 2'd2) : (step_r == 2'd1);

  always_comb begin
    unique case (step_r)
      2'd0: begin
        mx = am_r;
        my = (cmd_r == CMD_MUL) ? bm_r : bdm_r;
      end
      2'd1: begin
        priority if (addsub) begin
          mx = bm_r;
          my = adm_r;
        end else if (cmd_r == CMD_MUL) begin
          mx = adm_r;
          my = bdm_r;
        end else begin
          mx = adm_r;
          my = bm_r;
        end
      end
      default: begin
        mx = adm_r;
        my = bdm_r;
      end
    endcase
  end

  assign prod = PW'(mx) * PW'(my);

  // signed-magnitude sum of the two cross products
  logic [NW-1:0] pa_x, pb_x, sum_m, sum_mag;
  logic [NW:0]   dif;
  logic          sb, sum_s;

  assign pa_x  = NW'(pa_r);
  assign pb_x  = NW'(pb_r);
  assign sum_m = pa_x + pb_x;
  assign dif   = {1'b0, pa_x} - {1'b0, pb_x};
  assign sb    = pbs_r ^ (cmd_r == CMD_SUB);

  always_comb begin
    priority if (pas_r == sb) begin
      sum_mag = sum_m;
      sum_s   = pas_r;
    end else if (!dif[NW]) begin
      sum_mag = dif[NW-1:0];
      sum_s   = pas_r;
    end else begin
      sum_mag = (~dif[NW-1:0]) + 1'b1;
      sum_s   = sb;
    end
  end

  // reducer
  logic          red_start, red_done;
  logic [NW-1:0] red_qn, red_qd;

  fra_reduce #(
    .MAG_W (NW)
  ) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .num_i (nm_r),
    .den_i (NW'(dn_r)),
    .done  (red_done),
    .qn    (red_qn),
    .qd    (red_qd)
  );

  // result packing
  logic [ENW-1:0] ne, nv;
  logic [EDW-1:0] de, dv;
  logic           dn_s;
  logic           out_free;

  assign dn_s     = ads_r ^ ((cmd_r == CMD_DIV) ? bs_r : bds_r);
  assign ne       = ENW'(nm_r);
  assign nv       = nms_r ? ((~ne) + 1'b1) : ne;
  assign de       = EDW'(dn_r);
  assign dv       = dn_s ? ((~de) + 1'b1) : de;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    err_nxt         = err_r;
    step_nxt        = step_r;
    am_nxt          = am_r;
    adm_nxt         = adm_r;
    bm_nxt          = bm_r;
    bdm_nxt         = bdm_r;
    as_nxt          = as_r;
    ads_nxt         = ads_r;
    bs_nxt          = bs_r;
    bds_nxt         = bds_r;
    pa_nxt          = pa_r;
    pb_nxt          = pb_r;
    dn_nxt          = dn_r;
    pas_nxt         = pas_r;
    pbs_nxt         = pbs_r;
    nm_nxt          = nm_r;
    nms_nxt         = nms_r;
    red_start       = 1'b0;
    out_res_num_nxt = out_res_num_r;
    out_res_den_nxt = out_res_den_r;
    out_status_nxt  = out_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          err_nxt   = in_err;
          am_nxt    = a_num_m;
          adm_nxt   = a_den_m;
          bm_nxt    = b_num_m;
          bdm_nxt   = b_den_m;
          as_nxt    = a_num_x[W-1];
          ads_nxt   = a_den_x[W-1];
          bs_nxt    = b_num_x[W-1];
          bds_nxt   = b_den_x[W-1];
          step_nxt  = 2'd0;
          state_nxt = in_err ? S_OUT : S_MUL;
        end
      end
      S_MUL: begin
        unique case (step_r)
          2'd0: begin
            pa_nxt  = prod;
            pas_nxt = (prod != '0) && (as_r ^ ((cmd_r == CMD_MUL) ? bs_r : bds_r));
          end
          2'd1: begin
            if (addsub) begin
              pb_nxt  = prod;
              pbs_nxt = (prod != '0) && (bs_r ^ ads_r);
            end else begin
              dn_nxt = prod;
            end
          end
          default: begin
            dn_nxt = prod;
          end
        endcase
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (addsub) begin
          nm_nxt  = sum_mag;
          nms_nxt = sum_s && (sum_mag != '0);
        end else begin
          nm_nxt  = pa_x;
          nms_nxt = pas_r;
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // reduce only when both magnitudes are at least two
        if ((|nm_r[NW-1:1]) && (|dn_r[PW-1:1])) begin
          red_start = 1'b1;
          state_nxt = S_RED;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RED: begin
        if (red_done) begin
          nm_nxt    = red_qn;
          dn_nxt    = red_qd[PW-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_res_num_nxt = '0;
            out_res_den_nxt = '0;
            out_status_nxt  = 1'b1;
          end else begin
            out_res_num_nxt = nv[RES_NUM_W-1:0];
            out_res_den_nxt = dv[RES_DEN_W-1:0];
            out_status_nxt  = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    err_r         <= err_nxt;
    step_r        <= step_nxt;
    am_r          <= am_nxt;
    adm_r         <= adm_nxt;
    bm_r          <= bm_nxt;
    bdm_r         <= bdm_nxt;
    as_r          <= as_nxt;
    ads_r         <= ads_nxt;
    bs_r          <= bs_nxt;
    bds_r         <= bds_nxt;
    pa_r          <= pa_nxt;
    pb_r          <= pb_nxt;
    dn_r          <= dn_nxt;
    pas_r         <= pas_nxt;
    pbs_r         <= pbs_nxt;
    nm_r          <= nm_nxt;
    nms_r         <= nms_nxt;
    out_res_num_r <= out_res_num_nxt;
    out_res_den_r <= out_res_den_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_res_num = out_res_num_r;
  assign out_res_den = out_res_den_r;
  assign out_status  = out_status_r;

endmodule

FILE: rtl/core/fra_reduce.sv
module fra_reduce
  import fra_pkg::*;
#(
  parameter int MAG_W = 2 * OPERAND_WIDTH_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] num_i,
  input  logic [MAG_W-1:0] den_i,
  output logic             done,
  output logic [MAG_W-1:0] qn,
  output logic [MAG_W-1:0] qd
);

  localparam int KW = $clog2(MAG_W);

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_TWOS = 3'd1;
  localparam logic [2:0] R_GCD  = 3'd2;
  localparam logic [2:0] R_SHL  = 3'd3;
  localparam logic [2:0] R_DIVN = 3'd4;
  localparam logic [2:0] R_DIVD = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [MAG_W-1:0] u_r, u_nxt;
  logic [MAG_W-1:0] v_r, v_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [KW-1:0]    cnt_r, cnt_nxt;
  logic [MAG_W-1:0] n_r, n_nxt;
  logic [MAG_W-1:0] d_r, d_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] dvd_r, dvd_nxt;
  logic [MAG_W-1:0] qn_r, qn_nxt;
  logic             done_r, done_nxt;

  // shared subtractor: gcd compare/subtract and divider trial subtract
  logic [MAG_W:0]   sub_a, sub_b;
  logic [MAG_W+1:0] diff;
  logic             ge;
  logic [MAG_W:0]   sh;
  logic             in_div;

  assign in_div = (state_r == R_DIVN) || (state_r == R_DIVD);
  assign sh     = {rem_r, dvd_r[MAG_W-1]};
  assign sub_a  = in_div ? sh : {1'b0, u_r};
  assign sub_b  = in_div ? {1'b0, u_r} : {1'b0, v_r};
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge     = !diff[MAG_W+1];

  always_comb begin
    state_nxt = state_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    qn_nxt    = qn_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          u_nxt     = num_i;
          v_nxt     = den_i;
          n_nxt     = num_i;
          d_nxt     = den_i;
          k_nxt     = '0;
          state_nxt = R_TWOS;
        end
      end
      R_TWOS: begin
        if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = R_GCD;
        end
      end
      R_GCD: begin
        priority if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (diff == '0) begin
          state_nxt = R_SHL;
        end else if (ge) begin
          u_nxt = diff[MAG_W-1:0];
        end else begin
          v_nxt = (~diff[MAG_W-1:0]) + 1'b1;
        end
      end
      R_SHL: begin
        // restore common factors of two; u then holds the divisor
        if (k_r != '0) begin
          u_nxt = u_r << 1;
          k_nxt = k_r - 1'b1;
        end else begin
          rem_nxt   = '0;
          dvd_nxt   = n_r;
          cnt_nxt   = KW'(MAG_W - 1);
          state_nxt = R_DIVN;
        end
      end
      R_DIVN, R_DIVD: begin
        rem_nxt = ge ? diff[MAG_W-1:0] : sh[MAG_W-1:0];
        dvd_nxt = {dvd_r[MAG_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (state_r == R_DIVN) begin
            qn_nxt    = dvd_nxt;
            rem_nxt   = '0;
            dvd_nxt   = d_r;
            cnt_nxt   = KW'(MAG_W - 1);
            state_nxt = R_DIVD;
          end else begin
            done_nxt  = 1'b1;
            state_nxt = R_IDLE;
          end
        end
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    qn_r  <= qn_nxt;
  end

  assign done = done_r;
  assign qn   = qn_r;
  assign qd   = dvd_r;

endmodule
